@@ rtl/frr_pkg.sv @@
// ----------------------------------------------------------------------------
// frr_pkg
// Shared types and constants for the fixed order-1 rice residual decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package frr_pkg;

   // field widths
   localparam int SAMPLE_W     = 16;
   localparam int BLOCK_W      = 17;
   localparam int COUNT_W      = 16;
   localparam int FIELD_W      = 17;
   localparam int ERROR_W      = 2;

   // queue depths
   localparam int REQ_DEPTH    = 2;
   localparam int RSP_DEPTH    = 4;

   // block size limits and reset value
   localparam logic [BLOCK_W-1:0] BLOCK_SIZE_RESET = 17'd4096;
   localparam logic [BLOCK_W-1:0] BLOCK_SIZE_MAX   = 17'd65536;

   // unary quotient saturates here
   localparam logic [COUNT_W-1:0] MAX_UNARY = 16'hFFFF;

   // request opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   // residual coding methods
   localparam logic [1:0] METHOD_RICE4 = 2'b00;
   localparam logic [1:0] METHOD_RICE5 = 2'b01;

   // escape codes for the rice parameter
   localparam logic [3:0] ESCAPE_RICE4 = 4'hF;
   localparam logic [4:0] ESCAPE_RICE5 = 5'h1F;

   // error codes
   localparam logic [ERROR_W-1:0] ERR_NONE   = 2'd0;
   localparam logic [ERROR_W-1:0] ERR_METHOD = 2'd1;
   localparam logic [ERROR_W-1:0] ERR_ESCAPE = 2'd2;

   typedef enum logic {
      KIND_START,
      KIND_BYTE
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_METHOD,
      PH_ORDER,
      PH_PARAM,
      PH_UNARY,
      PH_REM,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      SEQ_TAKE,
      SEQ_BITS,
      SEQ_FLUSH
   } seq_type;

   // classified request held in the front queue
   typedef struct packed {
      kind_type              kind;
      logic [7:0]            stream_byte;
      logic [SAMPLE_W-1:0]   warmup_sample;
   } req_item_type;

   // one result held in the result queue
   typedef struct packed {
      logic [SAMPLE_W-1:0]   sample;
      logic                  last;
      logic                  block_done;
      logic [ERROR_W-1:0]    error;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/frr_front.sv @@
// ----------------------------------------------------------------------------
// frr_front
// Request queue: accepts and classifies items ahead of the bit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module frr_front import frr_pkg::*; #(
   parameter int DEPTH = REQ_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output      logic                       req_full,
   input  wire logic                       req_opcode,
   input  wire logic [7:0]                 req_stream_byte,
   input  wire logic signed [SAMPLE_W-1:0] req_warmup_sample,
   output      req_item_type               head,
   output      logic                       head_valid,
   input  wire logic                       head_pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   req_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_write;
   logic             do_read;
   req_item_type     new_item;

   assign req_full   = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_write   = req_push && !req_full;
   assign do_read    = head_pop && head_valid;

   // classify the incoming item
   always_comb begin
      new_item.kind          = (req_opcode == OP_START) ? KIND_START : KIND_BYTE;
      new_item.stream_byte   = req_stream_byte;
      new_item.warmup_sample = req_warmup_sample;
   end

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (!do_write && do_read) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

@@ rtl/frr_back.sv @@
// ----------------------------------------------------------------------------
// frr_back
// Bit-serial residual decoder: one stream bit per cycle while the result queue
// has room, through the method, order, parameter, unary and remainder fields.
// ----------------------------------------------------------------------------
`default_nettype none

module frr_back import frr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [BLOCK_W-1:0]   block_size,
   input  wire req_item_type         head,
   input  wire logic                 head_valid,
   output      logic                 head_pop,
   input  wire logic                 out_full,
   output      logic                 out_push,
   output      rsp_item_type         out_item
);

   seq_type              seq_ff, seq_in;
   phase_type            phase_ff, phase_in;
   logic [6:0]           byte_ff, byte_in;
   logic [2:0]           bit_pos_ff, bit_pos_in;
   logic [4:0]           bit_cnt_ff, bit_cnt_in;
   logic [FIELD_W-1:0]   field_ff, field_in;
   logic                 wide5_ff, wide5_in;
   logic [3:0]           order_ff, order_in;
   logic [4:0]           rice_k_ff, rice_k_in;
   logic [COUNT_W-1:0]   unary_ff, unary_in;
   logic [COUNT_W-1:0]   parts_left_ff, parts_left_in;
   logic [COUNT_W-1:0]   samples_left_ff, samples_left_in;
   logic [COUNT_W-1:0]   part_count_ff, part_count_in;
   logic [SAMPLE_W-1:0]  prev_ff, prev_in;
   logic                 pend_valid_ff, pend_valid_in;
   rsp_item_type         pend_ff, pend_in;

   logic [BLOCK_W-1:0]   eff_size;
   logic                 cur_bit;
   logic [FIELD_W-1:0]   fs_shift;
   logic [4:0]           cnt_inc;
   logic [FIELD_W-1:0]   emit_field;
   logic [FIELD_W-1:0]   q_shift;
   logic [FIELD_W-1:0]   folded;
   logic [SAMPLE_W-1:0]  res_word;
   logic [SAMPLE_W-1:0]  emit_sample;
   logic [COUNT_W-1:0]   samples_dec;
   logic [COUNT_W-1:0]   part_dec;
   logic [COUNT_W-1:0]   parts_dec;
   logic [BLOCK_W-1:0]   len_full;
   logic [BLOCK_W-1:0]   len_adj;
   logic                 first_part;
   logic                 param_done;
   logic                 is_escape;

   logic                 step;
   logic                 final_bit;
   logic                 do_emit;
   logic                 res_valid;
   rsp_item_type         res;

   // block size clamped to the supported range
   always_comb begin
      if (block_size == '0) begin
         eff_size = BLOCK_W'(1);
      end else if (block_size > BLOCK_SIZE_MAX) begin
         eff_size = BLOCK_SIZE_MAX;
      end else begin
         eff_size = block_size;
      end
   end

   // current stream bit, msb first
   assign cur_bit  = (seq_ff == SEQ_TAKE) ? head.stream_byte[7] : byte_ff[bit_pos_ff];
   assign fs_shift = {field_ff[FIELD_W-2:0], cur_bit};
   assign cnt_inc  = bit_cnt_ff + 5'd1;

   // residual: quotient and remainder, zigzag unfolded, added with wrap
   assign emit_field  = (phase_ff == PH_REM) ? fs_shift : field_ff;
   assign q_shift     = {1'b0, unary_ff} << rice_k_ff;
   assign folded      = q_shift | emit_field;
   assign res_word    = folded[0] ? ~folded[FIELD_W-1:1] : folded[FIELD_W-1:1];
   assign emit_sample = prev_ff + res_word;

   // counters after one more sample or partition
   assign samples_dec = (samples_left_ff != '0) ? samples_left_ff - 1'b1 : '0;
   assign part_dec    = (part_count_ff != '0) ? part_count_ff - 1'b1 : '0;
   assign parts_dec   = (parts_left_ff != '0) ? parts_left_ff - 1'b1 : '0;

   // partition length, first partition one short
   assign len_full   = eff_size >> order_ff;
   assign first_part = ({1'b0, parts_left_ff} == (BLOCK_W'(1) << order_ff));
   always_comb begin
      if (first_part) begin
         len_adj = (len_full != '0) ? len_full - 1'b1 : '0;
      end else begin
         len_adj = len_full;
      end
   end

   assign param_done = wide5_ff ? (cnt_inc == 5'd5) : (cnt_inc == 5'd4);
   assign is_escape  = wide5_ff ? (fs_shift[4:0] == ESCAPE_RICE5)
                                : (fs_shift[3:0] == ESCAPE_RICE4);

   // sequencer, field decode and result ordering
   always_comb begin
      seq_in          = seq_ff;
      phase_in        = phase_ff;
      byte_in         = byte_ff;
      bit_pos_in      = bit_pos_ff;
      bit_cnt_in      = bit_cnt_ff;
      field_in        = field_ff;
      wide5_in        = wide5_ff;
      order_in        = order_ff;
      rice_k_in       = rice_k_ff;
      unary_in        = unary_ff;
      parts_left_in   = parts_left_ff;
      samples_left_in = samples_left_ff;
      part_count_in   = part_count_ff;
      prev_in         = prev_ff;
      pend_valid_in   = pend_valid_ff;
      pend_in         = pend_ff;
      head_pop        = 1'b0;
      out_push        = 1'b0;
      out_item        = '0;
      step            = 1'b0;
      final_bit       = 1'b0;
      do_emit         = 1'b0;
      res_valid       = 1'b0;
      res             = '0;

      // item sequencing
      case (seq_ff)
         SEQ_TAKE: begin
            if (head_valid && !out_full) begin
               head_pop = 1'b1;
               if (head.kind == KIND_START) begin
                  prev_in             = head.warmup_sample;
                  samples_left_in     = COUNT_W'(eff_size - 1'b1);
                  bit_cnt_in          = '0;
                  field_in            = '0;
                  wide5_in            = 1'b0;
                  order_in            = '0;
                  rice_k_in           = '0;
                  unary_in            = '0;
                  parts_left_in       = '0;
                  part_count_in       = '0;
                  phase_in            = (eff_size == BLOCK_W'(1)) ? PH_IDLE : PH_METHOD;
                  out_push            = 1'b1;
                  out_item.sample     = head.warmup_sample;
                  out_item.last       = 1'b1;
                  out_item.block_done = (eff_size == BLOCK_W'(1));
                  out_item.error      = ERR_NONE;
               end else begin
                  step       = 1'b1;
                  byte_in    = head.stream_byte[6:0];
                  bit_pos_in = 3'd6;
                  seq_in     = SEQ_BITS;
               end
            end
         end
         SEQ_BITS: begin
            if (!out_full) begin
               step       = 1'b1;
               final_bit  = (bit_pos_ff == '0);
               bit_pos_in = bit_pos_ff - 1'b1;
               if (final_bit) begin
                  seq_in = SEQ_TAKE;
               end
            end
         end
         SEQ_FLUSH: begin
            if (!out_full) begin
               out_push      = 1'b1;
               out_item      = pend_ff;
               out_item.last = 1'b1;
               pend_valid_in = 1'b0;
               seq_in        = SEQ_TAKE;
            end
         end
         default: begin
            seq_in = SEQ_TAKE;
         end
      endcase

      if (step) begin
         // field decode of one bit
         case (phase_ff)
            PH_METHOD: begin
               field_in   = fs_shift;
               bit_cnt_in = cnt_inc;
               if (cnt_inc == 5'd2) begin
                  bit_cnt_in = '0;
                  field_in   = '0;
                  phase_in   = PH_ORDER;
                  if (fs_shift[1:0] == METHOD_RICE4) begin
                     wide5_in = 1'b0;
                  end else if (fs_shift[1:0] == METHOD_RICE5) begin
                     wide5_in = 1'b1;
                  end else begin
                     phase_in  = PH_ERROR;
                     res_valid = 1'b1;
                     res.error = ERR_METHOD;
                  end
               end
            end
            PH_ORDER: begin
               field_in   = fs_shift;
               bit_cnt_in = cnt_inc;
               if (cnt_inc == 5'd4) begin
                  order_in      = fs_shift[3:0];
                  parts_left_in = COUNT_W'(1) << fs_shift[3:0];
                  phase_in      = PH_PARAM;
                  bit_cnt_in    = '0;
                  field_in      = '0;
               end
            end
            PH_PARAM: begin
               field_in   = fs_shift;
               bit_cnt_in = cnt_inc;
               if (param_done) begin
                  if (is_escape) begin
                     phase_in  = PH_ERROR;
                     res_valid = 1'b1;
                     res.error = ERR_ESCAPE;
                  end else begin
                     rice_k_in     = fs_shift[4:0];
                     part_count_in = COUNT_W'(len_adj);
                     parts_left_in = parts_dec;
                     bit_cnt_in    = '0;
                     field_in      = '0;
                     unary_in      = '0;
                     if (len_adj != '0) begin
                        phase_in = PH_UNARY;
                     end else if (parts_dec == '0) begin
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_PARAM;
                     end
                  end
               end
            end
            PH_UNARY: begin
               if (!cur_bit) begin
                  if (unary_ff != MAX_UNARY) begin
                     unary_in = unary_ff + 1'b1;
                  end
               end else if (rice_k_ff == '0) begin
                  do_emit = 1'b1;
               end else begin
                  phase_in   = PH_REM;
                  bit_cnt_in = '0;
                  field_in   = '0;
               end
            end
            PH_REM: begin
               field_in   = fs_shift;
               bit_cnt_in = cnt_inc;
               if (cnt_inc >= rice_k_ff) begin
                  do_emit = 1'b1;
               end
            end
            default: begin
               // idle or after an error: bits are dropped
            end
         endcase

         // one decoded sample
         if (do_emit) begin
            prev_in         = emit_sample;
            samples_left_in = samples_dec;
            part_count_in   = part_dec;
            unary_in        = '0;
            bit_cnt_in      = '0;
            field_in        = '0;
            res_valid       = 1'b1;
            res.sample      = emit_sample;
            res.block_done  = (samples_dec == '0);
            res.error       = ERR_NONE;
            if (samples_dec == '0) begin
               phase_in = PH_IDLE;
            end else if (part_dec != '0) begin
               phase_in = PH_UNARY;
            end else if (parts_left_ff == '0) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_PARAM;
            end
         end

         // hold back one result so the final one of the item can carry last
         if (!final_bit) begin
            if (res_valid) begin
               if (pend_valid_ff) begin
                  out_push = 1'b1;
                  out_item = pend_ff;
               end
               pend_in       = res;
               pend_valid_in = 1'b1;
            end
         end else begin
            if (res_valid) begin
               if (pend_valid_ff) begin
                  out_push = 1'b1;
                  out_item = pend_ff;
                  pend_in  = res;
                  seq_in   = SEQ_FLUSH;
               end else begin
                  out_push      = 1'b1;
                  out_item      = res;
                  out_item.last = 1'b1;
               end
            end else if (pend_valid_ff) begin
               out_push      = 1'b1;
               out_item      = pend_ff;
               out_item.last = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
      end
   end

   // control and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff          <= SEQ_TAKE;
         phase_ff        <= PH_IDLE;
         bit_pos_ff      <= '0;
         bit_cnt_ff      <= '0;
         field_ff        <= '0;
         wide5_ff        <= 1'b0;
         order_ff        <= '0;
         rice_k_ff       <= '0;
         unary_ff        <= '0;
         parts_left_ff   <= '0;
         samples_left_ff <= '0;
         part_count_ff   <= '0;
         prev_ff         <= '0;
         pend_valid_ff   <= 1'b0;
      end else begin
         seq_ff          <= seq_in;
         phase_ff        <= phase_in;
         bit_pos_ff      <= bit_pos_in;
         bit_cnt_ff      <= bit_cnt_in;
         field_ff        <= field_in;
         wide5_ff        <= wide5_in;
         order_ff        <= order_in;
         rice_k_ff       <= rice_k_in;
         unary_ff        <= unary_in;
         parts_left_ff   <= parts_left_in;
         samples_left_ff <= samples_left_in;
         part_count_ff   <= part_count_in;
         prev_ff         <= prev_in;
         pend_valid_ff   <= pend_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      pend_ff <= pend_in;
   end

endmodule

`default_nettype wire

@@ rtl/frr_rsp_queue.sv @@
// ----------------------------------------------------------------------------
// frr_rsp_queue
// Result queue between the bit decoder and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module frr_rsp_queue import frr_pkg::*; #(
   parameter int DEPTH = RSP_DEPTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire rsp_item_type  push_item,
   output      logic          full,
   input  wire logic          pop,
   output      logic          empty,
   output      rsp_item_type  head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_write;
   logic             do_read;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head     = mem_ff[rd_ptr_ff];
   assign do_write = push && !full;
   assign do_read  = pop && !empty;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (!do_write && do_read) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ rtl/flac_rice_residual_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// flac_rice_residual_decoder_unit
// Fixed order-1 rice residual decoder for one subframe of 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* is a queue input: an item transfers when req_push is high and
//    req_full is low. A start item (opcode 0) carries the warm-up sample, a
//    byte item (opcode 1) carries eight stream bits, msb first.
//  - rsp_* is a queue output: the oldest result sits on the ports while
//    rsp_empty is low and transfers when rsp_pop is high.
//  - csr_write_enable/csr_write_data set the block size; write it only while
//    the block is idle.
//  - a start item is written through to the result queue as the decoder takes
//    it; a byte item is decoded one stream bit per cycle while the result
//    queue has room, with an extra flush step when a sample is decoded on its
//    final bit while an earlier sample of the same byte is still held back;
//    the bit-serial decoder sets this rate.
//  - a two-entry request queue and a four-entry result queue let each side
//    stall on its own; when the result queue fills, the decoder stops on the
//    current bit and the request queue fills behind it.
//  - synchronous reset empties both queues, sets the block size to 4096 and
//    returns the decoder to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module flac_rice_residual_decoder_unit import frr_pkg::*; #(
   parameter int REQ_QUEUE_DEPTH = REQ_DEPTH,
   parameter int RSP_QUEUE_DEPTH = RSP_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output      logic                       req_full,
   input  wire logic                       req_opcode,
   input  wire logic [7:0]                 req_stream_byte,
   input  wire logic signed [SAMPLE_W-1:0] req_warmup_sample,
   output      logic                       rsp_empty,
   input  wire logic                       rsp_pop,
   output      logic signed [SAMPLE_W-1:0] rsp_sample,
   output      logic                       rsp_last,
   output      logic                       rsp_block_done,
   output      logic [ERROR_W-1:0]         rsp_error,
   input  wire logic                       csr_write_enable,
   input  wire logic [BLOCK_W-1:0]         csr_write_data
);

   logic [BLOCK_W-1:0] block_size_ff;
   req_item_type       head;
   logic               head_valid;
   logic               head_pop;
   logic               out_full;
   logic               out_push;
   rsp_item_type       out_item;
   rsp_item_type       rsp_head;

   // block size register
   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BLOCK_SIZE_RESET;
      end else if (csr_write_enable) begin
         block_size_ff <= csr_write_data;
      end
   end

   // request queue
   frr_front #(
      .DEPTH (REQ_QUEUE_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_opcode        (req_opcode),
      .req_stream_byte   (req_stream_byte),
      .req_warmup_sample (req_warmup_sample),
      .head              (head),
      .head_valid        (head_valid),
      .head_pop          (head_pop)
   );

   // bit-serial decoder
   frr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .block_size (block_size_ff),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_item   (out_item)
   );

   // result queue
   frr_rsp_queue #(
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_item (out_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   assign rsp_sample     = rsp_head.sample;
   assign rsp_last       = rsp_head.last;
   assign rsp_block_done = rsp_head.block_done;
   assign rsp_error      = rsp_head.error;

endmodule

`default_nettype wire
